>>> hdl/srtrb_pkg.sv
// Package for the serial receive/transmit ring buffers.
// Holds queue sizing, command/status codes, FSM states and pointer helpers.
// No dependencies.
package srtrb_pkg;

  localparam int QueueDepth = 256;
  localparam int PtrW       = $clog2(QueueDepth);
  localparam int CntW       = PtrW + 1;
  localparam int DropW      = 16;

  localparam logic [7:0] CharCr = 8'h0D;
  localparam logic [7:0] CharLf = 8'h0A;
  localparam logic [DropW-1:0] DropMax = {DropW{1'b1}};

  typedef logic [PtrW-1:0] ptr_t;
  typedef logic [CntW-1:0] cnt_t;

  typedef enum logic [1:0] {
    CMD_RX_BYTE  = 2'd0,
    CMD_TX_READY = 2'd1,
    CMD_HOST_GET = 2'd2,
    CMD_HOST_PUT = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_PUT2
  } state_e;

  typedef struct packed {
    logic [1:0]       status;
    logic [7:0]       out_byte;
    logic             line_send;
    logic             tx_irq_enabled;
    logic [DropW-1:0] overflow_count;
  } res_t;

  typedef struct packed {
    logic       we;
    ptr_t       addr;
    logic [7:0] data;
  } ram_wr_t;

  function automatic ptr_t ptr_adv(ptr_t p);
    return (p == ptr_t'(QueueDepth - 1)) ? '0 : p + ptr_t'(1);
  endfunction

  function automatic cnt_t used_slots(ptr_t head, ptr_t tail);
    cnt_t h;
    cnt_t t;
    h = {1'b0, head};
    t = {1'b0, tail};
    return (t >= h) ? (t - h) : (t + cnt_t'(QueueDepth) - h);
  endfunction

endpackage

>>> hdl/srtrb_in_if.sv
// Input channel interface: one event (cmd, data_byte) per transaction.
// Depends on nothing.
interface srtrb_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] data_byte;

  modport source (output valid, output cmd, output data_byte, input ready);
  modport sink   (input valid, input cmd, input data_byte, output ready);
endinterface

>>> hdl/srtrb_out_if.sv
// Output channel interface: one result per transaction.
// Depends on nothing.
interface srtrb_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [7:0]  out_byte;
  logic        line_send;
  logic        tx_irq_enabled;
  logic [15:0] overflow_count;

  modport source (output valid, output status, output out_byte, output line_send,
                  output tx_irq_enabled, output overflow_count, input ready);
  modport sink   (input valid, input status, input out_byte, input line_send,
                  input tx_irq_enabled, input overflow_count, output ready);
endinterface

>>> hdl/srtrb_ram.sv
// Generic single-write, single-read synchronous RAM, registered read data.
// No dependencies.
module srtrb_ram #(
  parameter int Depth = 256,
  parameter int Width = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

>>> hdl/srtrb_ctrl.sv
// Event sequencer: queue pointers, drop counter, irq enable and both byte RAMs.
// Depends on srtrb_pkg, srtrb_in_if, srtrb_ram.
module srtrb_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  srtrb_in_if.sink      in_i,
  input  logic          obuf_full_i,
  output logic          res_push_o,
  output srtrb_pkg::res_t res_o
);
  import srtrb_pkg::*;

  state_e state_q, state_d;
  ptr_t rx_head_q, rx_head_d, rx_tail_q, rx_tail_d;
  ptr_t tx_head_q, tx_head_d, tx_tail_q, tx_tail_d;
  logic [DropW-1:0] drop_q, drop_d;
  logic irq_q, irq_d;
  logic pop_tx_q, pop_tx_d;

  ram_wr_t rx_wr, tx_wr;
  logic [7:0] rx_rdata, tx_rdata, pop_byte;

  logic accept;
  cmd_e cmd;
  logic rx_full, rx_empty, tx_empty, put_lf, put_reject;
  cnt_t tx_free;
  logic go_read, go_put2;

  assign in_i.ready = (state_q == S_IDLE) && !obuf_full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign cmd        = cmd_e'(in_i.cmd);

  assign rx_full    = used_slots(rx_head_q, rx_tail_q) == cnt_t'(QueueDepth - 1);
  assign rx_empty   = rx_head_q == rx_tail_q;
  assign tx_empty   = tx_head_q == tx_tail_q;
  assign tx_free    = cnt_t'(QueueDepth - 1) - used_slots(tx_head_q, tx_tail_q);
  assign put_lf     = in_i.data_byte == CharLf;
  assign put_reject = tx_free < (put_lf ? cnt_t'(2) : cnt_t'(1));

  assign go_read = accept && (((cmd == CMD_HOST_GET) && !rx_empty) ||
                              ((cmd == CMD_TX_READY) && !tx_empty));
  assign go_put2 = accept && (cmd == CMD_HOST_PUT) && put_lf && !put_reject;

  // Reads are issued from the head pointers every cycle; data for a pop is
  // taken in S_READ, the cycle after the head address was presented.
  srtrb_ram #(.Depth(QueueDepth), .Width(8)) u_rx_ram (
    .clk_i   (clk_i),
    .we_i    (rx_wr.we),
    .waddr_i (rx_wr.addr),
    .wdata_i (rx_wr.data),
    .raddr_i (rx_head_q),
    .rdata_o (rx_rdata)
  );

  srtrb_ram #(.Depth(QueueDepth), .Width(8)) u_tx_ram (
    .clk_i   (clk_i),
    .we_i    (tx_wr.we),
    .waddr_i (tx_wr.addr),
    .wdata_i (tx_wr.data),
    .raddr_i (tx_head_q),
    .rdata_o (tx_rdata)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (go_read) begin
          state_d = S_READ;
        end else if (go_put2) begin
          state_d = S_PUT2;
        end
      end
      S_READ:  state_d = S_IDLE;
      S_PUT2:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  assign pop_byte = pop_tx_q ? tx_rdata :
                    ((rx_rdata == CharCr) ? CharLf : rx_rdata);

  always_comb begin
    rx_head_d  = rx_head_q;
    rx_tail_d  = rx_tail_q;
    tx_head_d  = tx_head_q;
    tx_tail_d  = tx_tail_q;
    drop_d     = drop_q;
    irq_d      = irq_q;
    pop_tx_d   = pop_tx_q;
    rx_wr      = '{we: 1'b0, addr: rx_tail_q, data: in_i.data_byte};
    tx_wr      = '{we: 1'b0, addr: tx_tail_q, data: in_i.data_byte};
    res_push_o = 1'b0;
    res_o      = '0;
    res_o.status = ST_DONE;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_push_o = 1'b1;
          unique case (cmd)
            CMD_RX_BYTE: begin
              if (rx_full) begin
                if (drop_q != DropMax) begin
                  drop_d = drop_q + DropW'(1);
                end
                res_o.status = ST_FULL;
              end else begin
                rx_wr.we  = 1'b1;
                rx_tail_d = ptr_adv(rx_tail_q);
              end
            end
            CMD_TX_READY: begin
              if (!tx_empty) begin
                tx_head_d  = ptr_adv(tx_head_q);
                pop_tx_d   = 1'b1;
                res_push_o = 1'b0;
              end else begin
                irq_d        = 1'b0;
                res_o.status = ST_EMPTY;
              end
            end
            CMD_HOST_GET: begin
              if (!rx_empty) begin
                rx_head_d  = ptr_adv(rx_head_q);
                pop_tx_d   = 1'b0;
                res_push_o = 1'b0;
              end else begin
                res_o.status = ST_EMPTY;
              end
            end
            CMD_HOST_PUT: begin
              if (put_reject) begin
                res_o.status = ST_FULL;
              end else begin
                // LF goes in as CR now, the LF itself follows in S_PUT2
                tx_wr.we   = 1'b1;
                tx_wr.data = put_lf ? CharCr : in_i.data_byte;
                tx_tail_d  = ptr_adv(tx_tail_q);
                irq_d      = 1'b1;
              end
            end
            default: ;
          endcase
          res_o.tx_irq_enabled = irq_d;
          res_o.overflow_count = drop_d;
        end
      end
      S_READ: begin
        res_push_o           = 1'b1;
        res_o.out_byte       = pop_byte;
        res_o.line_send      = pop_tx_q;
        res_o.tx_irq_enabled = irq_q;
        res_o.overflow_count = drop_q;
      end
      S_PUT2: begin
        tx_wr.we   = 1'b1;
        tx_wr.data = CharLf;
        tx_tail_d  = ptr_adv(tx_tail_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      rx_head_q <= '0;
      rx_tail_q <= '0;
      tx_head_q <= '0;
      tx_tail_q <= '0;
      drop_q    <= '0;
      irq_q     <= 1'b0;
      pop_tx_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      rx_head_q <= rx_head_d;
      rx_tail_q <= rx_tail_d;
      tx_head_q <= tx_head_d;
      tx_tail_q <= tx_tail_d;
      drop_q    <= drop_d;
      irq_q     <= irq_d;
      pop_tx_q  <= pop_tx_d;
    end
  end

endmodule

>>> hdl/srtrb_obuf.sv
// Two-entry result buffer between the sequencer and the output channel.
// Depends on srtrb_pkg, srtrb_out_if.
module srtrb_obuf (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  srtrb_pkg::res_t res_i,
  output logic            full_o,
  srtrb_out_if.source     out_o
);
  import srtrb_pkg::*;

  res_t slot_q [2];
  logic wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic pop;
  res_t head;

  assign head   = slot_q[rd_q];
  assign pop    = out_o.valid && out_o.ready;
  assign full_o = cnt_q == 2'd2;

  assign out_o.valid          = cnt_q != 2'd0;
  assign out_o.status         = head.status;
  assign out_o.out_byte       = head.out_byte;
  assign out_o.line_send      = head.line_send;
  assign out_o.tx_irq_enabled = head.tx_irq_enabled;
  assign out_o.overflow_count = head.overflow_count;

  always_comb begin
    wr_d  = push_i ? ~wr_q : wr_q;
    rd_d  = pop ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push_i} - {1'b0, pop};
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

>>> hdl/serial_rx_tx_ring_buffers.sv
// Serial receive/transmit ring buffers: two 256-slot byte queues (255 bytes each)
// in single-port-write RAMs with registered reads. One event is handled at a time:
// a received byte, an empty pop, a rejected put or a plain host put is finished
// in S_IDLE; a pop (host get or transmitter ready) goes on to S_READ because the
// RAM read is registered, and a put of LF goes on to S_PUT2 since CR and LF are
// written through the one write port in turn. Results pass through a two-entry
// buffer, so a new event is accepted while up to one earlier result still waits.
// All storage is in RAM without reset; there is no clearing pass after reset.
module serial_rx_tx_ring_buffers (
  input  logic        clk_i,
  input  logic        rst_ni,
  srtrb_in_if.sink    in_i,
  srtrb_out_if.source out_o
);
  import srtrb_pkg::*;

  logic res_push;
  res_t res;
  logic obuf_full;

  srtrb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .obuf_full_i (obuf_full),
    .res_push_o  (res_push),
    .res_o       (res)
  );

  srtrb_obuf u_obuf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .res_i  (res),
    .full_o (obuf_full),
    .out_o  (out_o)
  );

endmodule

>>> hdl/srtrb_checker.sv
// Port-level checks for serial_rx_tx_ring_buffers, attached by bind.
// Depends on srtrb_pkg.
module srtrb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [1:0]  status_i,
  input logic [7:0]  out_byte_i,
  input logic        line_send_i,
  input logic        tx_irq_i,
  input logic [15:0] overflow_i
);
  import srtrb_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i &&
      $stable({status_i, out_byte_i, line_send_i, tx_irq_i, overflow_i}))
    else $error("result changed while stalled");

  a_send_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && line_send_i |-> status_i == ST_DONE)
    else $error("line byte with non-done status");

  a_empty_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i != ST_DONE) |-> !line_send_i && (out_byte_i == 8'h00))
    else $error("byte reported on failed event");

  // host gets map CR to LF, other non-line results carry zero
  a_no_cr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !line_send_i |-> out_byte_i != CharCr)
    else $error("CR delivered to host");

endmodule

bind serial_rx_tx_ring_buffers srtrb_checker u_srtrb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .status_i    (out_o.status),
  .out_byte_i  (out_o.out_byte),
  .line_send_i (out_o.line_send),
  .tx_irq_i    (out_o.tx_irq_enabled),
  .overflow_i  (out_o.overflow_count)
);

>>> verif/tb_serial_rx_tx_ring_buffers.sv
// Testbench for serial_rx_tx_ring_buffers: random and directed events against a cycle-free
// predictor of both byte queues, with randomly stalled input and output channels.
// Depends on srtrb_pkg, srtrb_in_if, srtrb_out_if and the block itself.
module tb_serial_rx_tx_ring_buffers;
  import srtrb_pkg::*;

  localparam int CycleLimit = 1000000;
  localparam int RandItems  = 560;
  localparam int IdlePct    = 17;

  typedef struct {
    logic       drain;  // hold off until every expected result is in
    cmd_e       op;
    logic [7:0] data;
  } event_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  srtrb_in_if  in_if ();
  srtrb_out_if out_if ();

  serial_rx_tx_ring_buffers i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #4 clk_i = ~clk_i;

  event_t event_q[$];
  res_t   due_results[$];
  int     mismatches  = 0;
  int     accepted    = 0;
  int     results_in  = 0;
  int     cycle_cnt   = 0;
  logic   in_fire     = 1'b0;
  logic   no_idle;

  assign no_idle = (accepted >= 1200) && (accepted < 1700);

  // Shadow copy of both queues
  logic [7:0]  rx_mem [QueueDepth];
  logic [7:0]  tx_mem [QueueDepth];
  int          rx_rd = 0, rx_wr = 0, tx_rd = 0, tx_wr = 0;
  logic [15:0] drops  = '0;
  logic        irq_en = 1'b0;

  function automatic int wrap_inc(int p);
    return (p + 1) % QueueDepth;
  endfunction

  function automatic int room(int rd, int wr);
    return QueueDepth - 1 - ((wr - rd + QueueDepth) % QueueDepth);
  endfunction

  function automatic res_t serve_event(cmd_e op, logic [7:0] b);
    res_t r;
    r = '0;
    case (op)
      CMD_RX_BYTE: begin
        if (room(rx_rd, rx_wr) == 0) begin
          if (drops != DropMax) drops = drops + 16'd1;
          r.status = ST_FULL;
        end else begin
          rx_mem[rx_wr] = b;
          rx_wr = wrap_inc(rx_wr);
        end
      end
      CMD_TX_READY: begin
        if (tx_rd != tx_wr) begin
          r.out_byte  = tx_mem[tx_rd];
          r.line_send = 1'b1;
          tx_rd = wrap_inc(tx_rd);
        end else begin
          irq_en   = 1'b0;
          r.status = ST_EMPTY;
        end
      end
      CMD_HOST_GET: begin
        if (rx_rd != rx_wr) begin
          r.out_byte = (rx_mem[rx_rd] == CharCr) ? CharLf : rx_mem[rx_rd];
          rx_rd = wrap_inc(rx_rd);
        end else begin
          r.status = ST_EMPTY;
        end
      end
      default: begin
        // LF goes out as CR LF, both or neither
        if (room(tx_rd, tx_wr) < ((b == CharLf) ? 2 : 1)) begin
          r.status = ST_FULL;
        end else begin
          if (b == CharLf) begin
            tx_mem[tx_wr] = CharCr;
            tx_wr = wrap_inc(tx_wr);
          end
          tx_mem[tx_wr] = b;
          tx_wr  = wrap_inc(tx_wr);
          irq_en = 1'b1;
        end
      end
    endcase
    r.tx_irq_enabled = irq_en;
    r.overflow_count = drops;
    return r;
  endfunction

  task automatic note_error(string msg);
    $display("mismatch @%0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic queue_event(cmd_e op, logic [7:0] b);
    event_q.push_back('{drain: 1'b0, op: op, data: b});
  endtask

  task automatic queue_pause();
    event_q.push_back('{drain: 1'b1, op: CMD_HOST_GET, data: 8'h00});
  endtask

  function automatic logic [7:0] line_byte();
    int pick;
    pick = $urandom_range(99);
    if (pick < 12) return CharCr;
    if (pick < 17) return CharLf;
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [7:0] host_byte();
    int pick;
    pick = $urandom_range(99);
    if (pick < 15) return CharLf;
    if (pick < 20) return CharCr;
    return 8'($urandom_range(255));
  endfunction

  // Driver: new event presented at the falling edge once the previous one is taken
  always @(negedge clk_i) begin
    if (rst_ni && (!in_if.valid || in_fire)) begin
      if (event_q.size() != 0 && event_q[0].drain) begin
        in_if.valid <= 1'b0;
        if (due_results.size() == 0) void'(event_q.pop_front());
      end else if (event_q.size() == 0 || (!no_idle && $urandom_range(99) < IdlePct)) begin
        in_if.valid <= 1'b0;
      end else begin
        in_if.valid     <= 1'b1;
        in_if.cmd       <= event_q[0].op;
        in_if.data_byte <= event_q[0].data;
        void'(event_q.pop_front());
      end
    end
  end

  always @(negedge clk_i) begin
    out_if.ready <= no_idle || ($urandom_range(99) >= IdlePct);
  end

  // Monitor: results checked first, then the accepted event is predicted
  always @(posedge clk_i) begin : monitor
    res_t want;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        if (due_results.size() == 0) begin
          note_error($sformatf("result %0d arrived with nothing outstanding", results_in));
        end else begin
          want = due_results.pop_front();
          if (out_if.status !== want.status)
            note_error($sformatf("result %0d status %0d, expected %0d",
                                 results_in, out_if.status, want.status));
          if (out_if.out_byte !== want.out_byte)
            note_error($sformatf("result %0d out_byte %02h, expected %02h",
                                 results_in, out_if.out_byte, want.out_byte));
          if (out_if.line_send !== want.line_send)
            note_error($sformatf("result %0d line_send %0b, expected %0b",
                                 results_in, out_if.line_send, want.line_send));
          if (out_if.tx_irq_enabled !== want.tx_irq_enabled)
            note_error($sformatf("result %0d tx_irq_enabled %0b, expected %0b",
                                 results_in, out_if.tx_irq_enabled, want.tx_irq_enabled));
          if (out_if.overflow_count !== want.overflow_count)
            note_error($sformatf("result %0d overflow_count %0d, expected %0d",
                                 results_in, out_if.overflow_count, want.overflow_count));
        end
        results_in++;
      end
      in_fire = in_if.valid && in_if.ready;
      if (in_fire) begin
        due_results.push_back(serve_event(cmd_e'(in_if.cmd), in_if.data_byte));
        accepted++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("serial_rx_tx_ring_buffers regression: fail");
      $finish;
    end
  end

  initial begin : stimulus
    int         n_rand;
    int         seg;
    int         len;
    cmd_e       op;
    logic [7:0] b;

    rst_ni           = 1'b0;
    in_if.valid      = 1'b0;
    in_if.cmd        = CMD_RX_BYTE;
    in_if.data_byte  = 8'h00;
    out_if.ready     = 1'b0;

    // Directed: empty pops, byte extremes, CR/LF handling both ways
    queue_event(CMD_HOST_GET, 8'h00);
    queue_event(CMD_TX_READY, 8'hFF);
    queue_event(CMD_HOST_PUT, 8'h00);
    queue_event(CMD_HOST_PUT, 8'hFF);
    queue_event(CMD_HOST_PUT, CharLf);
    queue_event(CMD_HOST_PUT, CharCr);
    repeat (5) queue_event(CMD_TX_READY, 8'h00);
    queue_event(CMD_TX_READY, 8'h00);
    queue_event(CMD_RX_BYTE, CharCr);
    queue_event(CMD_RX_BYTE, 8'hFF);
    queue_event(CMD_RX_BYTE, 8'h00);
    queue_event(CMD_RX_BYTE, CharLf);
    repeat (5) queue_event(CMD_HOST_GET, 8'hFF);
    queue_pause();

    // Transmit queue to its edges: LF with one free slot, then with exactly two
    repeat (QueueDepth + 4) queue_event(CMD_TX_READY, 8'($urandom_range(255)));
    repeat (QueueDepth - 2) begin
      b = 8'($urandom_range(255));
      queue_event(CMD_HOST_PUT, (b == CharLf) ? CharCr : b);
    end
    queue_event(CMD_HOST_PUT, CharLf);
    queue_event(CMD_HOST_PUT, 8'h5A);
    queue_event(CMD_HOST_PUT, 8'hA5);
    queue_event(CMD_HOST_PUT, CharLf);
    repeat (2) queue_event(CMD_TX_READY, 8'h00);
    queue_event(CMD_HOST_PUT, CharLf);
    queue_event(CMD_HOST_PUT, CharLf);

    // Receive queue to full, a few drops, then room again
    repeat (QueueDepth + 4) queue_event(CMD_HOST_GET, 8'($urandom_range(255)));
    repeat (QueueDepth - 1) queue_event(CMD_RX_BYTE, line_byte());
    repeat (3) queue_event(CMD_RX_BYTE, line_byte());
    repeat (2) queue_event(CMD_HOST_GET, 8'h00);
    repeat (3) queue_event(CMD_RX_BYTE, line_byte());

    // Random segments: mixed traffic, fill bursts and drain bursts
    n_rand = 0;
    while (n_rand < RandItems) begin
      seg = $urandom_range(0, 5);
      len = (seg < 3) ? $urandom_range(10, 60) : $urandom_range(50, 300);
      for (int k = 0; k < len; k++) begin
        case (seg)
          3: queue_event(CMD_RX_BYTE, line_byte());
          4: queue_event(CMD_HOST_PUT, host_byte());
          5: queue_event($urandom_range(1) ? CMD_HOST_GET : CMD_TX_READY,
                         8'($urandom_range(255)));
          default: begin
            op = cmd_e'($urandom_range(3));
            queue_event(op, (op == CMD_RX_BYTE) ? line_byte() : host_byte());
          end
        endcase
      end
      n_rand += len;
    end
    queue_pause();

    // Short mixed tail after the pause
    repeat (40) begin
      op = cmd_e'($urandom_range(3));
      queue_event(op, (op == CMD_RX_BYTE) ? line_byte() : host_byte());
    end

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (event_q.size() != 0 || in_if.valid || due_results.size() != 0)
      @(negedge clk_i);
    repeat (16) @(negedge clk_i);
    if (due_results.size() != 0)
      note_error($sformatf("%0d results never arrived", due_results.size()));

    if (mismatches == 0) begin
      $display("serial_rx_tx_ring_buffers regression: pass");
    end else begin
      $display("serial_rx_tx_ring_buffers regression: fail");
    end
    $finish;
  end

endmodule
